// File: hdl/rte_pkg.sv
// Package for the retransmission timeout estimator.
// Holds the command codes, register indexes, field widths and reset values.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package rte_pkg;

  // Widths of the fields on the channels.
  localparam int FIELD_W   = 24;
  localparam int CMD_W     = 2;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 3;

  // The backoff count stops here.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Commands carried by each input transfer.
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_BACKOFF = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_REINIT  = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_RTT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DEV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT = 3'd4;

  // Reset values in microseconds.
  localparam int RST_MIN_TIMEOUT  = 100000;
  localparam int RST_MAX_TIMEOUT  = 2000000;
  localparam int RST_INIT_RTT     = 0;
  localparam int RST_INIT_DEV     = 0;
  localparam int RST_INIT_TIMEOUT = 1000000;

endpackage

`default_nettype wire

// File: hdl/rte_if.sv
// Channel interfaces of the retransmission timeout estimator.
// Input, result and configuration write channels with valid/ready handshakes.
// Depends on rte_pkg for the field widths.
`default_nettype none

// Input channel: one command per transfer.
interface rte_in_if import rte_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FIELD_W-1:0] measured_rtt_us;

  modport source (output valid, output cmd, output measured_rtt_us, input ready);
  modport sink   (input valid, input cmd, input measured_rtt_us, output ready);
endinterface

// Result channel: one result per input transfer.
interface rte_out_if import rte_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] timeout_us;
  logic [FIELD_W-1:0] smoothed_rtt_us;
  logic [FIELD_W-1:0] rtt_deviation_us;
  logic [CNT_W-1:0]   backoff_count;

  modport source (output valid, output timeout_us, output smoothed_rtt_us,
                  output rtt_deviation_us, output backoff_count, input ready);
  modport sink   (input valid, input timeout_us, input smoothed_rtt_us,
                  input rtt_deviation_us, input backoff_count, output ready);
endinterface

// Configuration write channel.
interface rte_cfg_if import rte_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rtt_timeout_estimator.sv
// Retransmission timeout estimator, top level.
// Smoothed RTT and deviation tracking with clamped timeout and backoff.
// Depends on rte_pkg and the channel interfaces in rte_if.sv.
//
//   Channel   Direction  Transfer carries
//   cfg_ch    in         register index, write data (always ready)
//   in_ch     in         cmd, measured_rtt_us
//   out_ch    out        timeout_us, smoothed_rtt_us, rtt_deviation_us, backoff_count
//
// Each item passes through the input register and its result is then registered in
// the output register, one item per cycle while the result channel is not stalled.
// The rate is set by the state update loop.
// Reset (rst_n, synchronous) empties both registers and loads the reset state.
// A stalled result holds; a new item is still taken while the input register
// can move on or is empty.
`default_nettype none

module rtt_timeout_estimator import rte_pkg::*; #(
  parameter int TIME_WIDTH = 24,
  parameter int FRAC_BITS  = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  rte_cfg_if.sink   cfg_ch,
  rte_in_if.sink    in_ch,
  rte_out_if.source out_ch
);

  localparam int TW = TIME_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int FW = TW + FB;

  // Configuration registers.
  logic [TW-1:0] min_to_r, max_to_r, init_rtt_r, init_dev_r, init_to_r;

  // Estimator state.
  logic [FW-1:0]    est_r, est_nxt;
  logic [FW-1:0]    dev_r, dev_nxt;
  logic [TW-1:0]    to_r, to_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pipeline registers.
  logic          s1_valid_r;
  cmd_t          s1_cmd_r;
  logic [TW-1:0] s1_meas_r;
  logic          out_valid_r;
  logic [FIELD_W-1:0] out_to_r, out_est_r, out_dev_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic advance;
  logic in_ready;

  // Sample datapath.
  logic [FW-1:0]          meas_fx;
  logic signed [FW:0]     err;
  logic signed [FW+1:0]   est_sum;
  logic [FW:0]            aerr;
  logic signed [FW+1:0]   dev_diff;
  logic signed [FW+1:0]   dev_sum;
  logic [FW-1:0]          est_smp, dev_smp;
  logic [FW+2:0]          to_sum;
  logic [TW+2:0]          to_raw, to_lo;
  logic [TW-1:0]          to_smp, to_dbl;
  logic [CNT_W-1:0]       cnt_inc;

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_to_r   <= TW'(RST_MIN_TIMEOUT);
      max_to_r   <= TW'(RST_MAX_TIMEOUT);
      init_rtt_r <= TW'(RST_INIT_RTT);
      init_dev_r <= TW'(RST_INIT_DEV);
      init_to_r  <= TW'(RST_INIT_TIMEOUT);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_MIN_TIMEOUT:  min_to_r   <= TW'(cfg_ch.data);
        REG_MAX_TIMEOUT:  max_to_r   <= TW'(cfg_ch.data);
        REG_INIT_RTT:     init_rtt_r <= TW'(cfg_ch.data);
        REG_INIT_DEV:     init_dev_r <= TW'(cfg_ch.data);
        REG_INIT_TIMEOUT: init_to_r  <= TW'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the output register is
  // free or its result is being taken.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ready    = !s1_valid_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_cmd_r  <= cmd_t'(in_ch.cmd);
      s1_meas_r <= TW'(in_ch.measured_rtt_us);
    end
  end

  // Sample update: est += err/8 and dev += (|err| - dev)/4, rounding down.
  always_comb begin
    meas_fx  = FW'(s1_meas_r) << FB;
    err      = $signed({1'b0, meas_fx}) - $signed({1'b0, est_r});
    est_sum  = $signed({2'b00, est_r}) + (FW+2)'(err >>> 3);
    est_smp  = est_sum[FW-1:0];
    aerr     = err[FW] ? (FW+1)'(-err) : (FW+1)'(err);
    dev_diff = $signed({1'b0, aerr}) - $signed({2'b00, dev_r});
    dev_sum  = $signed({2'b00, dev_r}) + (dev_diff >>> 2);
    dev_smp  = dev_sum[FW-1:0];
  end

  // Timeout from the new estimate: integer part of est + 4*dev, min clamp
  // first and max clamp second, so max wins when the two cross.
  always_comb begin
    to_sum = {3'b000, est_smp} + {1'b0, dev_smp, 2'b00};
    to_raw = to_sum[FW+2:FB];
    to_lo  = (to_raw < {3'b000, min_to_r}) ? {3'b000, min_to_r} : to_raw;
    to_smp = (to_lo > {3'b000, max_to_r}) ? max_to_r : to_lo[TW-1:0];
  end

  // Backoff: saturating doubling and a saturating count.
  assign to_dbl  = to_r[TW-1] ? '1 : {to_r[TW-2:0], 1'b0};
  assign cnt_inc = (cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  // Next state by command.
  always_comb begin
    est_nxt = est_r;
    dev_nxt = dev_r;
    to_nxt  = to_r;
    cnt_nxt = cnt_r;
    unique case (s1_cmd_r)
      CMD_SAMPLE: begin
        est_nxt = est_smp;
        dev_nxt = dev_smp;
        to_nxt  = to_smp;
      end
      CMD_BACKOFF: begin
        to_nxt  = to_dbl;
        cnt_nxt = cnt_inc;
      end
      CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      CMD_REINIT: begin
        est_nxt = FW'(init_rtt_r) << FB;
        dev_nxt = FW'(init_dev_r) << FB;
        to_nxt  = init_to_r;
        cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  // State registers advance with each item that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      dev_r <= '0;
      to_r  <= TW'(RST_INIT_TIMEOUT);
      cnt_r <= '0;
    end else if (advance && s1_valid_r) begin
      est_r <= est_nxt;
      dev_r <= dev_nxt;
      to_r  <= to_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_to_r  <= FIELD_W'(to_nxt);
      out_est_r <= FIELD_W'(est_nxt[FW-1:FB]);
      out_dev_r <= FIELD_W'(dev_nxt[FW-1:FB]);
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.timeout_us       = out_to_r;
  assign out_ch.smoothed_rtt_us  = out_est_r;
  assign out_ch.rtt_deviation_us = out_dev_r;
  assign out_ch.backoff_count    = out_cnt_r;

endmodule

`default_nettype wire
